// ----- sv/hsv2rgb_pkg.sv -----
`default_nettype none
package hsv2rgb_pkg;

  localparam logic [7:0] K255       = 8'd255;
  localparam logic [7:0] K171       = 8'd171;
  localparam logic [7:0] K170       = 8'd170;
  localparam logic [7:0] K85        = 8'd85;
  localparam logic [4:0] RAMP_MASK  = 5'h1F;
  localparam logic [7:0] ONE_THIRD  = 8'(256 / 3);
  localparam logic [7:0] TWO_THIRDS = 8'((256 * 2) / 3);

  // the eight sections of the rainbow wheel, picked by the top hue bits
  typedef enum logic [2:0] {
    SEC_RED    = 3'd0,
    SEC_ORANGE = 3'd1,
    SEC_YELLOW = 3'd2,
    SEC_GREEN  = 3'd3,
    SEC_AQUA   = 3'd4,
    SEC_BLUE   = 3'd5,
    SEC_PURPLE = 3'd6,
    SEC_PINK   = 3'd7
  } sect_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // hue ramps plus saturation and brightness terms
  typedef struct packed {
    logic       valid;
    sect_t      sect;
    logic [7:0] t1;
    logic [7:0] t2;
    logic       sat_full;
    logic       sat_zero;
    logic [7:0] desat;
    logic [7:0] keep;
    logic       val_full;
    logic [7:0] vv;
  } prep_t;

  // desaturated color waiting for the brightness scale
  typedef struct packed {
    logic       valid;
    rgb_t       rgb;
    logic       val_full;
    logic [7:0] vv;
  } sat_t;

  // (i * (s + 1)) >> 8
  function automatic logic [7:0] scale8(input logic [7:0] i, input logic [7:0] s);
    logic [15:0] s1;
    logic [15:0] p;
    s1 = 16'(s) + 16'd1;
    p  = 16'(i) * s1;
    return p[15:8];
  endfunction

  // ((i * s) >> 8) plus one when both are nonzero
  function automatic logic [7:0] scale8_sq(input logic [7:0] i, input logic [7:0] s);
    logic [15:0] p;
    p = 16'(i) * 16'(s);
    return p[15:8] + 8'((i != 8'd0) && (s != 8'd0));
  endfunction

  function automatic rgb_t rainbow(input sect_t sect, input logic [7:0] t1,
                                   input logic [7:0] t2);
    rgb_t c;
    c = '0;
    case (sect)
      SEC_RED: begin
        c.red = K255 - t1; c.green = t1; c.blue = 8'd0;
      end
      SEC_ORANGE: begin
        c.red = K171; c.green = K85 + t1; c.blue = 8'd0;
      end
      SEC_YELLOW: begin
        c.red = K171 - t2; c.green = K170 + t1; c.blue = 8'd0;
      end
      SEC_GREEN: begin
        c.red = 8'd0; c.green = K255 - t1; c.blue = t1;
      end
      SEC_AQUA: begin
        c.red = 8'd0; c.green = K171 - t2; c.blue = K85 + t2;
      end
      SEC_BLUE: begin
        c.red = t1; c.green = 8'd0; c.blue = K255 - t1;
      end
      SEC_PURPLE: begin
        c.red = K85 + t1; c.green = 8'd0; c.blue = K171 - t1;
      end
      SEC_PINK: begin
        c.red = K170 + t1; c.green = 8'd0; c.blue = K85 - t1;
      end
      default: begin
        c = '0;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/hsv2rgb_prep.sv -----
`default_nettype none
module hsv2rgb_prep (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [7:0]          hue,
  input  wire logic [7:0]          saturation,
  input  wire logic [7:0]          brightness,
  output hsv2rgb_pkg::prep_t       prep_o
);
  import hsv2rgb_pkg::*;

  prep_t      prep_r;
  prep_t      prep_nxt;
  logic [7:0] ramp;
  logic [7:0] inv_sat;
  logic [7:0] desat;

  always_comb begin
    ramp     = {hue[4:0] & RAMP_MASK, 3'b000};
    inv_sat  = K255 - saturation;
    desat    = scale8_sq(inv_sat, inv_sat);

    prep_nxt          = '0;
    // synchronous reset clears the valid bit
    prep_nxt.valid    = in_valid & rst_n;
    prep_nxt.sect     = sect_t'(hue[7:5]);
    prep_nxt.t1       = scale8(ramp, ONE_THIRD);
    prep_nxt.t2       = scale8(ramp, TWO_THIRDS);
    prep_nxt.sat_full = (saturation == K255);
    prep_nxt.sat_zero = (saturation == 8'd0);
    prep_nxt.desat    = desat;
    prep_nxt.keep     = K255 - desat;
    prep_nxt.val_full = (brightness == K255);
    prep_nxt.vv       = scale8_sq(brightness, brightness);
  end

  always_ff @(posedge clk) begin
    prep_r <= prep_nxt;
  end

  assign prep_o = prep_r;

endmodule
`default_nettype wire

// ----- sv/hsv2rgb_sat.sv -----
`default_nettype none
module hsv2rgb_sat (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hsv2rgb_pkg::prep_t  prep_i,
  output hsv2rgb_pkg::sat_t        sat_o
);
  import hsv2rgb_pkg::*;

  sat_t sat_r;
  sat_t sat_nxt;
  rgb_t base;

  always_comb begin
    base = rainbow(prep_i.sect, prep_i.t1, prep_i.t2);

    sat_nxt          = '0;
    // synchronous reset clears the valid bit
    sat_nxt.valid    = prep_i.valid & rst_n;
    sat_nxt.val_full = prep_i.val_full;
    sat_nxt.vv       = prep_i.vv;
    if (prep_i.sat_full) begin
      sat_nxt.rgb = base;
    end else if (prep_i.sat_zero) begin
      sat_nxt.rgb = '{red: K255, green: K255, blue: K255};
    end else begin
      // scale toward the desaturation floor, then add it back
      sat_nxt.rgb.red   = scale8(base.red,   prep_i.keep) + prep_i.desat;
      sat_nxt.rgb.green = scale8(base.green, prep_i.keep) + prep_i.desat;
      sat_nxt.rgb.blue  = scale8(base.blue,  prep_i.keep) + prep_i.desat;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
  end

  assign sat_o = sat_r;

endmodule
`default_nettype wire

// ----- sv/hsv2rgb_val.sv -----
`default_nettype none
module hsv2rgb_val (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hsv2rgb_pkg::sat_t  sat_i,
  output logic                    out_valid,
  output hsv2rgb_pkg::rgb_t       rgb_o
);
  import hsv2rgb_pkg::*;

  logic valid_r;
  rgb_t rgb_r;
  rgb_t rgb_nxt;

  always_comb begin
    if (sat_i.val_full) begin
      rgb_nxt = sat_i.rgb;
    end else if (sat_i.vv == 8'd0) begin
      rgb_nxt = '0;
    end else begin
      rgb_nxt.red   = scale8(sat_i.rgb.red,   sat_i.vv);
      rgb_nxt.green = scale8(sat_i.rgb.green, sat_i.vv);
      rgb_nxt.blue  = scale8(sat_i.rgb.blue,  sat_i.vv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= sat_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    rgb_r <= rgb_nxt;
  end

  assign out_valid = valid_r;
  assign rgb_o     = rgb_r;

endmodule
`default_nettype wire

// ----- sv/hsv_to_rgb_rainbow.sv -----
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+---------------------------
// input    | start, busy, in_hue, in_saturation, in_brightness | start && !busy
// result   | out_valid, out_red, out_green, out_blue        | one-cycle strobe out_valid
//
// one transaction per clock while busy is low
// three register stages: hue ramps, saturation, brightness
// synchronous active-low reset clears only the valid bits; busy is high in reset
// the receiver cannot stall, so the pipeline never holds and never drops a transaction
`default_nettype none
module hsv_to_rgb_rainbow (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_hue,
  input  wire logic [7:0] in_saturation,
  input  wire logic [7:0] in_brightness,
  output logic            out_valid,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue
);
  import hsv2rgb_pkg::*;

  prep_t prep;
  sat_t  sat;
  rgb_t  rgb;
  logic  in_take;

  // no back-pressure downstream, so only reset blocks a new transaction
  assign busy    = ~rst_n;
  assign in_take = start & ~busy;

  // stage 1: section, one-third and two-third ramps, video-squared terms
  hsv2rgb_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_take),
    .hue        (in_hue),
    .saturation (in_saturation),
    .brightness (in_brightness),
    .prep_o     (prep)
  );

  // stage 2: rainbow section colors, blended toward white
  hsv2rgb_sat u_sat (
    .clk    (clk),
    .rst_n  (rst_n),
    .prep_i (prep),
    .sat_o  (sat)
  );

  // stage 3: brightness scale toward black, output register
  hsv2rgb_val u_val (
    .clk       (clk),
    .rst_n     (rst_n),
    .sat_i     (sat),
    .out_valid (out_valid),
    .rgb_o     (rgb)
  );

  assign out_red   = rgb.red;
  assign out_green = rgb.green;
  assign out_blue  = rgb.blue;

endmodule
`default_nettype wire

// ----- sv/hsv2rgb_chk.sv -----
`default_nettype none
module hsv2rgb_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] in_hue,
  input wire logic [7:0] in_saturation,
  input wire logic [7:0] in_brightness,
  input wire logic       out_valid,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // every accepted transaction comes out as a result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted transaction produced no result");

  // no result without a matching accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a matching transaction");

  // zero brightness is black
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_brightness, 3) == 8'd0)) |->
      (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("zero brightness did not give black");

  // zero saturation at full brightness is white
  a_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_saturation, 3) == 8'd0) &&
     ($past(in_brightness, 3) == 8'd255)) |->
      (out_red == 8'd255 && out_green == 8'd255 && out_blue == 8'd255))
    else $error("zero saturation did not give white");

  // in_hue must be known on every accepted transaction
  a_hue_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown(in_hue))
    else $error("unknown hue on an accepted transaction");

endmodule

bind hsv_to_rgb_rainbow hsv2rgb_chk u_hsv2rgb_chk (.*);
`default_nettype wire
